// ----- rtl/tsfs_pkg.sv -----
// ----------------------------------------------------------------------------
// tsfs_pkg: shared types and constants of the tethered spring force switch
// holds the sequencer states, datapath ops, divide jobs and fixed widths
// ----------------------------------------------------------------------------
`default_nettype none

package tsfs_pkg;

   // divider widths
   localparam int DIV_W     = 49;
   localparam int DSR_W     = 24;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   // shared multiplier widths
   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;

   // register indexes of the csr port
   localparam logic [1:0] REG_SPRING_K = 2'd0;
   localparam logic [1:0] REG_SWITCH   = 2'd1;
   localparam logic [1:0] REG_EQUIL    = 2'd2;
   localparam logic [1:0] REG_SMOOTH   = 2'd3;

   // reset values
   localparam logic [31:0] RESET_SPRING_K = 32'd65536;
   localparam logic [23:0] RESET_SWITCH   = 24'd1000;
   localparam logic [31:0] RESET_RATE     = 32'((2**24 + 500) / 1000);

   localparam logic [62:0] ENERGY_MAX = {63{1'b1}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_T_SUB,
      ST_T_CMP,
      ST_R_BEGIN,
      ST_DV_GO,
      ST_DV_WAIT,
      ST_M_ISSUE,
      ST_M_POST,
      ST_A_START,
      ST_AX_SETUP,
      ST_AX_FIN,
      ST_AX_SAT,
      ST_E_ACC,
      ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_XX,
      OP_X2X2,
      OP_X4X,
      OP_YY,
      OP_Y2Y2,
      OP_X4Y4,
      OP_Z630,
      OP_P70,
      OP_PX540,
      OP_PX420,
      OP_PX126,
      OP_PX5,
      OP_KD,
      OP_DD,
      OP_LF,
      OP_LS,
      OP_KH,
      OP_KL
   } op_type;

   typedef enum logic [1:0] {
      JOB_LAM,
      JOB_RATE,
      JOB_X,
      JOB_SRATE
   } job_type;

endpackage

`default_nettype wire

// ----- rtl/tsfs_div.sv -----
// ----------------------------------------------------------------------------
// tsfs_div: iterative unsigned divider
// restoring shift-subtract, one quotient bit per cycle, done pulses at the end
// ----------------------------------------------------------------------------
`default_nettype none

module tsfs_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [tsfs_pkg::DIV_W-1:0]    dividend,
   input  wire logic [tsfs_pkg::DSR_W-1:0]    divisor,
   output logic                               done,
   output logic [tsfs_pkg::DIV_W-1:0]         quotient
);

   logic [tsfs_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [tsfs_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [tsfs_pkg::DSR_W-1:0]     rem_ff, rem_in;
   logic [tsfs_pkg::DSR_W-1:0]     dsr_ff, dsr_in;
   logic                           done_ff, done_in;

   logic [tsfs_pkg::DSR_W:0]       shifted;
   logic [tsfs_pkg::DSR_W+1:0]     diff;
   logic                           take;

   always_comb begin
      shifted = {rem_ff, quo_ff[tsfs_pkg::DIV_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dsr_ff};
      take    = !diff[tsfs_pkg::DSR_W+1];
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      done_in = (cnt_ff == tsfs_pkg::DIV_CNT_W'(1));
      if (start) begin
         cnt_in = tsfs_pkg::DIV_CNT_W'(tsfs_pkg::DIV_W);
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - tsfs_pkg::DIV_CNT_W'(1);
         quo_in = {quo_ff[tsfs_pkg::DIV_W-2:0], take};
         rem_in = take ? diff[tsfs_pkg::DSR_W-1:0] : shifted[tsfs_pkg::DSR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ----- rtl/tsfs_mul.sv -----
// ----------------------------------------------------------------------------
// tsfs_mul: shared unsigned multiplier
// magnitude product with a register on its output
// ----------------------------------------------------------------------------
`default_nettype none

module tsfs_mul (
   input  wire logic                         clock,
   input  wire logic [tsfs_pkg::MUL_W-1:0]   op_a,
   input  wire logic [tsfs_pkg::MUL_W-1:0]   op_b,
   output logic [tsfs_pkg::PROD_W-1:0]       prod
);

   logic [tsfs_pkg::PROD_W-1:0] prod_ff, prod_in;

   always_comb begin
      prod_in = {{tsfs_pkg::MUL_W{1'b0}}, op_a} * {{tsfs_pkg::MUL_W{1'b0}}, op_b};
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ----- rtl/tethered_spring_force_switch.sv -----
// ----------------------------------------------------------------------------
// tethered_spring_force_switch: coupling switch for a tethered spring field
// ramps lambda over timestep ticks and blends atom forces with a spring force
// ----------------------------------------------------------------------------
// usage
//   req_* carries one item: a tick (req_mode 0) or an atom (req_mode 1).
//   rsp_* returns exactly one item for each req item, in order.
//   csr_* writes spring_k (0), switch_steps (1), equil_steps (2),
//   smooth_mode (3); csr_ready is high only while the block is idle.
// sequencing
//   one item at a time; req_stall stays high until the item is finished.
//   a tick whose ramp moves runs two divides of 49 quotient bits (linear)
//   or two divides plus twelve products (smooth), each product issued in
//   ST_M_ISSUE and taken in ST_M_POST; other ticks skip the arithmetic.
//   an atom in the tethered group uses four products per axis on the one
//   shared multiplier plus the two energy products.
//   atoms outside the group or in equilibration pass straight through.
// reset
//   synchronous, active high: registers go to their documented defaults,
//   lambda 0, rate round(2^24/1000), energy 0, elapsed count 0.
// stall
//   the finished item sits in the output register; while rsp_stall holds it
//   the next item may already be taken and computed, then waits at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module tethered_spring_force_switch (
   input  wire logic        clock,
   input  wire logic        reset,
   // input items
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_mode,
   input  wire logic        req_in_group,
   input  wire logic [31:0] req_pos_x,
   input  wire logic [31:0] req_pos_y,
   input  wire logic [31:0] req_pos_z,
   input  wire logic [31:0] req_tether_x,
   input  wire logic [31:0] req_tether_y,
   input  wire logic [31:0] req_tether_z,
   input  wire logic [31:0] req_force_in_x,
   input  wire logic [31:0] req_force_in_y,
   input  wire logic [31:0] req_force_in_z,
   input  wire logic        req_first_atom,
   // result items
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_force_out_x,
   output logic [31:0]      rsp_force_out_y,
   output logic [31:0]      rsp_force_out_z,
   output logic [62:0]      rsp_spring_energy,
   output logic [16:0]      rsp_coupling,
   output logic [31:0]      rsp_coupling_rate,
   // configuration writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   // polynomial constants in Q.24
   localparam logic [35:0] C315 = 36'd5284823040;
   localparam logic [35:0] C540 = 36'd9059696640;
   localparam logic [35:0] C420 = 36'd7046430720;
   localparam logic [35:0] C126 = 36'd2113929216;
   localparam logic [24:0] ONE24 = 25'd16777216;

   // sequencer
   tsfs_pkg::state_type state_ff, state_in;
   tsfs_pkg::op_type    op_ff, op_in;
   tsfs_pkg::job_type   job_ff, job_in;
   logic [1:0]  axis_ff, axis_in;
   logic        down_ff, down_in;
   logic        res_ff, res_in;
   logic [23:0] n_ff, n_in;
   logic [31:0] t_ff, t_in;

   // configuration
   logic [31:0] k_ff, k_in;
   logic [23:0] sw_ff, sw_in;
   logic [23:0] eq_ff, eq_in;
   logic        smooth_ff, smooth_in;

   // block state
   logic [31:0] elapsed_ff, elapsed_in;
   logic [16:0] lambda_ff, lambda_in;
   logic [31:0] rate_ff, rate_in;
   logic [62:0] energy_ff, energy_in;

   // captured atom
   logic        first_ff, first_in;
   logic        group_ff, group_in;
   logic [31:0] pos_ff [3];
   logic [31:0] pos_in [3];
   logic [31:0] teth_ff [3];
   logic [31:0] teth_in [3];
   logic [31:0] fin_ff [3];
   logic [31:0] fin_in [3];
   logic [31:0] fo_ff [3];
   logic [31:0] fo_in [3];

   // smooth ramp working registers
   logic [24:0] x_ff, x_in, y_ff, y_in;
   logic [24:0] x2_ff, x2_in, x4_ff, x4_in, x5_ff, x5_in;
   logic [24:0] y2_ff, y2_in, y4_ff, y4_in, z_ff, z_in;
   logic [34:0] w_ff, w_in;
   logic [35:0] p_ff, p_in;

   // atom working registers
   logic [32:0] ad_ff, ad_in;
   logic        dpos_ff, dpos_in;
   logic [31:0] fmag_ff, fmag_in;
   logic        fneg_ff, fneg_in;
   logic [31:0] fsmag_ff, fsmag_in;
   logic        fsneg_ff, fsneg_in;
   logic [49:0] sq_ff, sq_in;
   logic [48:0] t1_ff, t1_in;
   logic [49:0] acc_ff, acc_in;
   logic [33:0] am_ff, am_in;
   logic        aneg_ff, aneg_in;
   logic [50:0] hi_ff, hi_in;
   logic [62:0] e_ff, e_in;

   // output register
   logic        rv_ff, rv_in;
   logic [31:0] ofx_ff, ofx_in, ofy_ff, ofy_in, ofz_ff, ofz_in;
   logic [62:0] oen_ff, oen_in;
   logic [16:0] ocp_ff, ocp_in;
   logic [31:0] ort_ff, ort_in;

   // shared units
   logic                               div_start, div_done;
   logic [tsfs_pkg::DIV_W-1:0]         div_dividend, div_q;
   logic [tsfs_pkg::MUL_W-1:0]         mul_a, mul_b;
   logic [tsfs_pkg::PROD_W-1:0]        mul_p;

   // helpers
   logic        csr_acc, req_acc;
   logic [23:0] s_eff;
   logic [31:0] se, es, e2s;
   logic [67:0] rsum, ksum, lsum;
   logic [43:0] r24;
   logic [51:0] mag;
   logic [31:0] fsm;
   logic        pneg;
   logic [35:0] pabs, mag36, sm;
   logic [26:0] lr;
   logic [48:0] m49;
   logic [49:0] m50, add50, aabs, asum;
   logic [32:0] dd;
   logic [31:0] fsel, qneg;
   logic [63:0] rr, esum;
   logic [31:0] sat_res;

   tsfs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (s_eff),
      .done     (div_done),
      .quotient (div_q)
   );

   tsfs_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_p)
   );

   assign csr_ready = (state_ff == tsfs_pkg::ST_IDLE);
   assign req_stall = (state_ff != tsfs_pkg::ST_IDLE) | csr_valid;
   assign csr_acc   = csr_valid & csr_ready;
   assign req_acc   = req_valid & ~req_stall;

   always_comb begin
      // a zero switch span acts as one
      s_eff = (sw_ff == 24'd0) ? 24'd1 : sw_ff;
      se    = {8'd0, s_eff};
      es    = {8'd0, eq_ff} + se;
      e2s   = es + se;

      // product post-processing
      rsum  = mul_p + 68'd8388608;
      r24   = rsum[67:24];
      ksum  = mul_p + 68'd32768;
      mag   = ksum[67:16];
      lsum  = mul_p + 68'd65536;
      fsm   = (mag > 52'h80000000) ? 32'h80000000 : mag[31:0];

      pneg  = p_ff[35];
      pabs  = pneg ? (~p_ff + 36'd1) : p_ff;
      mag36 = {1'b0, r24[34:0]};
      sm    = pneg ? (~mag36 + 36'd1) : mag36;
      lr    = 27'((r24[34:0] + 35'd128) >> 8);

      m49   = {1'b0, mul_p[47:0]};
      m50   = {2'b00, mul_p[47:0]};
      add50 = fsneg_ff ? (~m50 + 50'd1) : m50;
      asum  = {t1_ff[48], t1_ff} + add50;
      aabs  = acc_ff[49] ? (~acc_ff + 50'd1) : acc_ff;

      dd    = {pos_ff[axis_ff][31], pos_ff[axis_ff]} - {teth_ff[axis_ff][31], teth_ff[axis_ff]};
      fsel  = fin_ff[axis_ff];
      qneg  = ~div_q[31:0] + 32'd1;

      rr    = {1'b0, hi_ff[47:0], 15'd0} + {17'd0, lsum[63:17]};
      esum  = {1'b0, energy_ff} + {1'b0, e_ff};

      if (!aneg_ff) begin
         sat_res = (am_ff > 34'h7FFFFFFF) ? 32'h7FFFFFFF : am_ff[31:0];
      end else begin
         sat_res = (am_ff > 34'h80000000) ? 32'h80000000 : (~am_ff[31:0] + 32'd1);
      end
   end

   // sequencer and datapath
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      job_in     = job_ff;
      axis_in    = axis_ff;
      down_in    = down_ff;
      res_in     = res_ff;
      n_in       = n_ff;
      t_in       = t_ff;
      k_in       = k_ff;
      sw_in      = sw_ff;
      eq_in      = eq_ff;
      smooth_in  = smooth_ff;
      elapsed_in = elapsed_ff;
      lambda_in  = lambda_ff;
      rate_in    = rate_ff;
      energy_in  = energy_ff;
      first_in   = first_ff;
      group_in   = group_ff;
      pos_in     = pos_ff;
      teth_in    = teth_ff;
      fin_in     = fin_ff;
      fo_in      = fo_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      x2_in      = x2_ff;
      x4_in      = x4_ff;
      x5_in      = x5_ff;
      y2_in      = y2_ff;
      y4_in      = y4_ff;
      z_in       = z_ff;
      w_in       = w_ff;
      p_in       = p_ff;
      ad_in      = ad_ff;
      dpos_in    = dpos_ff;
      fmag_in    = fmag_ff;
      fneg_in    = fneg_ff;
      fsmag_in   = fsmag_ff;
      fsneg_in   = fsneg_ff;
      sq_in      = sq_ff;
      t1_in      = t1_ff;
      acc_in     = acc_ff;
      am_in      = am_ff;
      aneg_in    = aneg_ff;
      hi_in      = hi_ff;
      e_in       = e_ff;
      rv_in      = rv_ff & rsp_stall;
      ofx_in     = ofx_ff;
      ofy_in     = ofy_ff;
      ofz_in     = ofz_ff;
      oen_in     = oen_ff;
      ocp_in     = ocp_ff;
      ort_in     = ort_ff;
      div_start  = 1'b0;
      mul_a      = '0;
      mul_b      = '0;

      // divide dividends, rounding half up by adding half the divisor
      case (job_ff)
         tsfs_pkg::JOB_LAM:  div_dividend = {9'd0, n_ff, 16'd0};
         tsfs_pkg::JOB_RATE: div_dividend = 49'd16777216;
         tsfs_pkg::JOB_X:    div_dividend = {1'b0, n_ff, 24'd0};
         default:            div_dividend = {14'd0, w_ff};
      endcase
      div_dividend = div_dividend + {26'd0, s_eff[23:1]};

      case (state_ff)
         tsfs_pkg::ST_IDLE: begin
            if (csr_acc) begin
               case (csr_index)
                  tsfs_pkg::REG_SPRING_K: k_in = csr_wdata;
                  tsfs_pkg::REG_SWITCH:   sw_in = csr_wdata[23:0];
                  tsfs_pkg::REG_EQUIL:    eq_in = csr_wdata[23:0];
                  tsfs_pkg::REG_SMOOTH:   smooth_in = csr_wdata[0];
                  default:                k_in = k_ff;
               endcase
               // ramp shape change before the first tick recomputes n = 0
               if ((csr_index == tsfs_pkg::REG_SWITCH || csr_index == tsfs_pkg::REG_SMOOTH)
                   && elapsed_ff == 32'd0) begin
                  n_in     = 24'd0;
                  down_in  = 1'b0;
                  res_in   = 1'b0;
                  state_in = tsfs_pkg::ST_R_BEGIN;
               end
            end else if (req_acc) begin
               res_in     = 1'b1;
               first_in   = req_first_atom;
               group_in   = req_in_group;
               pos_in[0]  = req_pos_x;
               pos_in[1]  = req_pos_y;
               pos_in[2]  = req_pos_z;
               teth_in[0] = req_tether_x;
               teth_in[1] = req_tether_y;
               teth_in[2] = req_tether_z;
               fin_in[0]  = req_force_in_x;
               fin_in[1]  = req_force_in_y;
               fin_in[2]  = req_force_in_z;
               if (!req_mode) begin
                  if (elapsed_ff != 32'hFFFFFFFF) begin
                     elapsed_in = elapsed_ff + 32'd1;
                  end
                  fo_in[0] = '0;
                  fo_in[1] = '0;
                  fo_in[2] = '0;
                  state_in = tsfs_pkg::ST_T_SUB;
               end else begin
                  // forces pass through unless blended later
                  fo_in[0] = req_force_in_x;
                  fo_in[1] = req_force_in_y;
                  fo_in[2] = req_force_in_z;
                  state_in = tsfs_pkg::ST_A_START;
               end
            end
         end

         tsfs_pkg::ST_T_SUB: begin
            if (elapsed_ff >= {8'd0, eq_ff}) begin
               t_in     = elapsed_ff - {8'd0, eq_ff};
               state_in = tsfs_pkg::ST_T_CMP;
            end else begin
               state_in = tsfs_pkg::ST_DONE;
            end
         end

         tsfs_pkg::ST_T_CMP: begin
            // ramp down wins where both spans meet
            if (t_ff >= es && t_ff <= e2s) begin
               n_in     = 24'(e2s - t_ff);
               down_in  = 1'b1;
               state_in = tsfs_pkg::ST_R_BEGIN;
            end else if (t_ff <= se) begin
               n_in     = t_ff[23:0];
               down_in  = 1'b0;
               state_in = tsfs_pkg::ST_R_BEGIN;
            end else begin
               state_in = tsfs_pkg::ST_DONE;
            end
         end

         tsfs_pkg::ST_R_BEGIN: begin
            job_in   = smooth_ff ? tsfs_pkg::JOB_X : tsfs_pkg::JOB_LAM;
            state_in = tsfs_pkg::ST_DV_GO;
         end

         tsfs_pkg::ST_DV_GO: begin
            div_start = 1'b1;
            state_in  = tsfs_pkg::ST_DV_WAIT;
         end

         tsfs_pkg::ST_DV_WAIT: begin
            if (div_done) begin
               case (job_ff)
                  tsfs_pkg::JOB_LAM: begin
                     lambda_in = div_q[16:0];
                     job_in    = tsfs_pkg::JOB_RATE;
                     state_in  = tsfs_pkg::ST_DV_GO;
                  end
                  tsfs_pkg::JOB_X: begin
                     x_in     = div_q[24:0];
                     y_in     = ONE24 - div_q[24:0];
                     op_in    = tsfs_pkg::OP_XX;
                     state_in = tsfs_pkg::ST_M_ISSUE;
                  end
                  default: begin
                     rate_in  = down_ff ? qneg : div_q[31:0];
                     state_in = tsfs_pkg::ST_DONE;
                  end
               endcase
            end
         end

         tsfs_pkg::ST_M_ISSUE: begin
            case (op_ff)
               tsfs_pkg::OP_XX:    begin mul_a = 34'(x_ff);  mul_b = 34'(x_ff);  end
               tsfs_pkg::OP_X2X2:  begin mul_a = 34'(x2_ff); mul_b = 34'(x2_ff); end
               tsfs_pkg::OP_X4X:   begin mul_a = 34'(x4_ff); mul_b = 34'(x_ff);  end
               tsfs_pkg::OP_YY:    begin mul_a = 34'(y_ff);  mul_b = 34'(y_ff);  end
               tsfs_pkg::OP_Y2Y2:  begin mul_a = 34'(y2_ff); mul_b = 34'(y2_ff); end
               tsfs_pkg::OP_X4Y4:  begin mul_a = 34'(x4_ff); mul_b = 34'(y4_ff); end
               tsfs_pkg::OP_Z630:  begin mul_a = 34'(z_ff);  mul_b = 34'd630;    end
               tsfs_pkg::OP_P70:   begin mul_a = 34'(x_ff);  mul_b = 34'd70;     end
               tsfs_pkg::OP_PX540,
               tsfs_pkg::OP_PX420,
               tsfs_pkg::OP_PX126: begin mul_a = pabs[33:0]; mul_b = 34'(x_ff);  end
               tsfs_pkg::OP_PX5:   begin mul_a = pabs[33:0]; mul_b = 34'(x5_ff); end
               tsfs_pkg::OP_KD:    begin mul_a = 34'(k_ff);  mul_b = 34'(ad_ff); end
               tsfs_pkg::OP_DD:    begin mul_a = 34'(ad_ff); mul_b = 34'(ad_ff); end
               tsfs_pkg::OP_LF: begin
                  mul_a = 34'(17'd65536 - lambda_ff);
                  mul_b = 34'(fmag_ff);
               end
               tsfs_pkg::OP_LS:    begin mul_a = 34'(lambda_ff); mul_b = 34'(fsmag_ff); end
               tsfs_pkg::OP_KH:    begin mul_a = 34'(k_ff); mul_b = 34'(sq_ff[49:32]); end
               tsfs_pkg::OP_KL:    begin mul_a = 34'(k_ff); mul_b = 34'(sq_ff[31:0]);  end
               default:            begin mul_a = '0; mul_b = '0; end
            endcase
            state_in = tsfs_pkg::ST_M_POST;
         end

         tsfs_pkg::ST_M_POST: begin
            state_in = tsfs_pkg::ST_M_ISSUE;
            case (op_ff)
               tsfs_pkg::OP_XX:   begin x2_in = r24[24:0]; op_in = tsfs_pkg::OP_X2X2; end
               tsfs_pkg::OP_X2X2: begin x4_in = r24[24:0]; op_in = tsfs_pkg::OP_X4X;  end
               tsfs_pkg::OP_X4X:  begin x5_in = r24[24:0]; op_in = tsfs_pkg::OP_YY;   end
               tsfs_pkg::OP_YY:   begin y2_in = r24[24:0]; op_in = tsfs_pkg::OP_Y2Y2; end
               tsfs_pkg::OP_Y2Y2: begin y4_in = r24[24:0]; op_in = tsfs_pkg::OP_X4Y4; end
               tsfs_pkg::OP_X4Y4: begin z_in = r24[24:0];  op_in = tsfs_pkg::OP_Z630; end
               tsfs_pkg::OP_Z630: begin w_in = mul_p[34:0]; op_in = tsfs_pkg::OP_P70; end
               tsfs_pkg::OP_P70: begin
                  p_in  = {2'b00, mul_p[33:0]} - C315;
                  op_in = tsfs_pkg::OP_PX540;
               end
               tsfs_pkg::OP_PX540: begin p_in = sm + C540; op_in = tsfs_pkg::OP_PX420; end
               tsfs_pkg::OP_PX420: begin p_in = sm - C420; op_in = tsfs_pkg::OP_PX126; end
               tsfs_pkg::OP_PX126: begin p_in = sm + C126; op_in = tsfs_pkg::OP_PX5;   end
               tsfs_pkg::OP_PX5: begin
                  // negative polynomial clamps to zero, above one clamps to one
                  if (pneg) begin
                     lambda_in = '0;
                  end else if (lr > 27'd65536) begin
                     lambda_in = 17'd65536;
                  end else begin
                     lambda_in = lr[16:0];
                  end
                  job_in   = tsfs_pkg::JOB_SRATE;
                  state_in = tsfs_pkg::ST_DV_GO;
               end
               tsfs_pkg::OP_KD: begin
                  fsneg_in = dpos_ff & (fsm != 32'd0);
                  fsmag_in = (dpos_ff || !fsm[31]) ? fsm : 32'h7FFFFFFF;
                  op_in    = tsfs_pkg::OP_DD;
               end
               tsfs_pkg::OP_DD: begin
                  sq_in = sq_ff + {1'b0, ksum[64:16]};
                  op_in = tsfs_pkg::OP_LF;
               end
               tsfs_pkg::OP_LF: begin
                  t1_in = fneg_ff ? (~m49 + 49'd1) : m49;
                  op_in = tsfs_pkg::OP_LS;
               end
               tsfs_pkg::OP_LS: begin
                  acc_in   = asum;
                  state_in = tsfs_pkg::ST_AX_FIN;
               end
               tsfs_pkg::OP_KH: begin
                  hi_in = mul_p[50:0];
                  op_in = tsfs_pkg::OP_KL;
               end
               tsfs_pkg::OP_KL: begin
                  if (hi_ff[50:48] != 3'd0 || rr[63]) begin
                     e_in = tsfs_pkg::ENERGY_MAX;
                  end else begin
                     e_in = rr[62:0];
                  end
                  state_in = tsfs_pkg::ST_E_ACC;
               end
               default: state_in = tsfs_pkg::ST_DONE;
            endcase
         end

         tsfs_pkg::ST_A_START: begin
            if (elapsed_ff < {8'd0, eq_ff}) begin
               // equilibration: pass through, energy untouched
               state_in = tsfs_pkg::ST_DONE;
            end else begin
               if (first_ff) begin
                  energy_in = '0;
               end
               if (group_ff) begin
                  axis_in  = 2'd0;
                  sq_in    = '0;
                  state_in = tsfs_pkg::ST_AX_SETUP;
               end else begin
                  state_in = tsfs_pkg::ST_DONE;
               end
            end
         end

         tsfs_pkg::ST_AX_SETUP: begin
            ad_in    = dd[32] ? (~dd + 33'd1) : dd;
            dpos_in  = !dd[32] && (dd != 33'd0);
            fneg_in  = fsel[31];
            fmag_in  = fsel[31] ? (~fsel + 32'd1) : fsel;
            op_in    = tsfs_pkg::OP_KD;
            state_in = tsfs_pkg::ST_M_ISSUE;
         end

         tsfs_pkg::ST_AX_FIN: begin
            aneg_in  = acc_ff[49];
            am_in    = 34'((aabs + 50'd32768) >> 16);
            state_in = tsfs_pkg::ST_AX_SAT;
         end

         tsfs_pkg::ST_AX_SAT: begin
            fo_in[axis_ff] = sat_res;
            if (axis_ff == 2'd2) begin
               op_in    = tsfs_pkg::OP_KH;
               state_in = tsfs_pkg::ST_M_ISSUE;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = tsfs_pkg::ST_AX_SETUP;
            end
         end

         tsfs_pkg::ST_E_ACC: begin
            energy_in = esum[63] ? tsfs_pkg::ENERGY_MAX : esum[62:0];
            state_in  = tsfs_pkg::ST_DONE;
         end

         tsfs_pkg::ST_DONE: begin
            if (!res_ff) begin
               state_in = tsfs_pkg::ST_IDLE;
            end else if (!rv_ff || !rsp_stall) begin
               rv_in    = 1'b1;
               ofx_in   = fo_ff[0];
               ofy_in   = fo_ff[1];
               ofz_in   = fo_ff[2];
               oen_in   = energy_ff;
               ocp_in   = lambda_ff;
               ort_in   = rate_ff;
               state_in = tsfs_pkg::ST_IDLE;
            end
         end

         default: state_in = tsfs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tsfs_pkg::ST_IDLE;
         op_ff      <= tsfs_pkg::OP_XX;
         job_ff     <= tsfs_pkg::JOB_LAM;
         axis_ff    <= 2'd0;
         down_ff    <= 1'b0;
         res_ff     <= 1'b0;
         k_ff       <= tsfs_pkg::RESET_SPRING_K;
         sw_ff      <= tsfs_pkg::RESET_SWITCH;
         eq_ff      <= '0;
         smooth_ff  <= 1'b0;
         elapsed_ff <= '0;
         lambda_ff  <= '0;
         rate_ff    <= tsfs_pkg::RESET_RATE;
         energy_ff  <= '0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         op_ff      <= op_in;
         job_ff     <= job_in;
         axis_ff    <= axis_in;
         down_ff    <= down_in;
         res_ff     <= res_in;
         k_ff       <= k_in;
         sw_ff      <= sw_in;
         eq_ff      <= eq_in;
         smooth_ff  <= smooth_in;
         elapsed_ff <= elapsed_in;
         lambda_ff  <= lambda_in;
         rate_ff    <= rate_in;
         energy_ff  <= energy_in;
         rv_ff      <= rv_in;
      end
      n_ff     <= n_in;
      t_ff     <= t_in;
      first_ff <= first_in;
      group_ff <= group_in;
      pos_ff   <= pos_in;
      teth_ff  <= teth_in;
      fin_ff   <= fin_in;
      fo_ff    <= fo_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      x2_ff    <= x2_in;
      x4_ff    <= x4_in;
      x5_ff    <= x5_in;
      y2_ff    <= y2_in;
      y4_ff    <= y4_in;
      z_ff     <= z_in;
      w_ff     <= w_in;
      p_ff     <= p_in;
      ad_ff    <= ad_in;
      dpos_ff  <= dpos_in;
      fmag_ff  <= fmag_in;
      fneg_ff  <= fneg_in;
      fsmag_ff <= fsmag_in;
      fsneg_ff <= fsneg_in;
      sq_ff    <= sq_in;
      t1_ff    <= t1_in;
      acc_ff   <= acc_in;
      am_ff    <= am_in;
      aneg_ff  <= aneg_in;
      hi_ff    <= hi_in;
      e_ff     <= e_in;
      ofx_ff   <= ofx_in;
      ofy_ff   <= ofy_in;
      ofz_ff   <= ofz_in;
      oen_ff   <= oen_in;
      ocp_ff   <= ocp_in;
      ort_ff   <= ort_in;
   end

   assign rsp_valid         = rv_ff;
   assign rsp_force_out_x   = ofx_ff;
   assign rsp_force_out_y   = ofy_ff;
   assign rsp_force_out_z   = ofz_ff;
   assign rsp_spring_energy = oen_ff;
   assign rsp_coupling      = ocp_ff;
   assign rsp_coupling_rate = ort_ff;

endmodule

`default_nettype wire
